// ===== hw/rtl/csq_pkg.sv =====
package csq_pkg;

  localparam int NUM_RESOURCES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF   = 16;

  localparam int ACT_W     = 2;
  localparam int RIDX_W    = 3;
  localparam int ID_W      = 8;
  localparam int CNT_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  localparam logic signed [CNT_W-1:0] CNT_MAX   = 8'sh7f;
  localparam logic signed [CNT_W-1:0] CNT_MIN   = 8'sh80;
  localparam logic signed [CNT_W-1:0] CNT_RESET = 8'sh01;

  typedef enum logic [ACT_W-1:0] {
    ACT_WAIT    = 2'd0,
    ACT_SIGNAL  = 2'd1,
    ACT_UNBLOCK = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_RES      = 2'd1,
    ST_QUEUE_FULL  = 2'd2,
    ST_HOLDER_FULL = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_en;
    logic scan_start;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/csq_ram.sv =====
module csq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/csq_ctrl.sv =====
module csq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  csq_pkg::dp_stat_t    stat,
  output csq_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: state_nxt = stat.need_scan ? S_SCAN : S_FINISH;
      S_SCAN:   if (stat.scan_done) state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.clr_en     = (state_r == S_CLEAR);
    cmd.scan_start = (state_r == S_DECODE) && stat.need_scan;
    cmd.scan_en    = (state_r == S_SCAN);
    cmd.finish     = (state_r == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== hw/rtl/csq_dp.sv =====
module csq_dp #(
  parameter int NUM_RESOURCES = csq_pkg::NUM_RESOURCES_DEF,
  parameter int QUEUE_DEPTH   = csq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  csq_pkg::ctrl_cmd_t              cmd,
  output csq_pkg::dp_stat_t               stat,
  input  logic [csq_pkg::ACT_W-1:0]       in_action,
  input  logic [csq_pkg::RIDX_W-1:0]      in_resource_index,
  input  logic [csq_pkg::ID_W-1:0]        in_process_id,
  input  logic                            cfg_wr,
  input  logic [csq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csq_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic [csq_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_granted,
  output logic                            out_woken_valid,
  output logic [csq_pkg::ID_W-1:0]        out_woken_id,
  output logic signed [csq_pkg::CNT_W-1:0] out_count_after
);

  localparam int SLOTS  = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int QI_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = FILL_W + 1;
  localparam int ID_W   = csq_pkg::ID_W;
  localparam int CNT_W  = csq_pkg::CNT_W;

  // request latch
  csq_pkg::action_t   act_r;
  logic [csq_pkg::RIDX_W-1:0] ridx_r;
  logic [ID_W-1:0]    pid_r;

  // per-resource state
  logic signed [CNT_W-1:0] unit_count_r [NUM_RESOURCES];
  logic [QI_W-1:0]         head_r       [NUM_RESOURCES];
  logic [FILL_W-1:0]       fill_r       [NUM_RESOURCES];

  // holder scan
  logic [QI_W-1:0]   rd_idx_r, chk_idx_r, hit_idx_r;
  logic              rd_live_r, chk_live_r, hit_r;
  logic [SLOT_W-1:0] clr_idx_r;

  // result registers
  logic                    out_valid_r;
  csq_pkg::status_t        res_status_r;
  logic                    res_granted_r, res_woken_valid_r;
  logic [ID_W-1:0]         res_woken_id_r;
  logic signed [CNT_W-1:0] res_count_r;

  logic [RES_W-1:0]        r_sel;
  logic                    idx_ok;
  logic signed [CNT_W-1:0] cnt_cur;
  logic [QI_W-1:0]         head_cur;
  logic [FILL_W-1:0]       fill_cur;
  logic                    cnt_pos, fill_full;
  logic [SLOT_W-1:0]       base;
  logic [TW-1:0]           tail_sum, tail_wrap;
  logic [QI_W-1:0]         tail_idx;

  logic              h_we;
  logic [SLOT_W-1:0] h_waddr, h_raddr;
  logic [ID_W:0]     h_wdata, h_rdata;
  logic              hq_valid;
  logic [ID_W-1:0]   hq_id;
  logic              match, scan_last;

  logic              w_we;
  logic [SLOT_W-1:0] w_waddr, w_raddr;
  logic [ID_W-1:0]   w_rdata;

  // finish outcome
  csq_pkg::status_t        res_status;
  logic                    res_granted, res_woken_valid;
  logic [ID_W-1:0]         res_woken_id;
  logic signed [CNT_W-1:0] res_count, cnt_nxt;
  logic [QI_W-1:0]         head_nxt;
  logic [FILL_W-1:0]       fill_nxt;
  logic                    h_we_fin, h_set_valid;

  assign r_sel    = ridx_r[RES_W-1:0];
  assign idx_ok   = int'(ridx_r) < NUM_RESOURCES;
  assign cnt_cur  = unit_count_r[r_sel];
  assign head_cur = head_r[r_sel];
  assign fill_cur = fill_r[r_sel];
  assign cnt_pos  = !cnt_cur[CNT_W-1] && (cnt_cur != '0);
  assign fill_full = (fill_cur == FILL_W'(QUEUE_DEPTH));
  assign base     = SLOT_W'(r_sel) * SLOT_W'(QUEUE_DEPTH);

  // tail slot of the circular queue
  assign tail_sum  = TW'(head_cur) + TW'(fill_cur);
  assign tail_wrap = (tail_sum >= TW'(QUEUE_DEPTH)) ? tail_sum - TW'(QUEUE_DEPTH) : tail_sum;
  assign tail_idx  = tail_wrap[QI_W-1:0];

  // holder scan: look for a free slot on wait, a matching id on signal
  assign hq_valid  = h_rdata[ID_W];
  assign hq_id     = h_rdata[ID_W-1:0];
  assign match     = chk_live_r &&
                     ((act_r == csq_pkg::ACT_WAIT) ? !hq_valid : (hq_valid && hq_id == pid_r));
  assign scan_last = chk_live_r && (chk_idx_r == QI_W'(QUEUE_DEPTH - 1));

  assign stat.clr_done  = (clr_idx_r == SLOT_W'(SLOTS - 1));
  assign stat.need_scan = idx_ok && ((act_r == csq_pkg::ACT_WAIT && cnt_pos) ||
                                     act_r == csq_pkg::ACT_SIGNAL);
  assign stat.scan_done = match || scan_last;

  always_comb begin
    res_status      = csq_pkg::ST_OK;
    res_granted     = 1'b0;
    res_woken_valid = 1'b0;
    res_woken_id    = '0;
    res_count       = cnt_cur;
    cnt_nxt         = cnt_cur;
    head_nxt        = head_cur;
    fill_nxt        = fill_cur;
    h_we_fin        = 1'b0;
    h_set_valid     = 1'b0;
    w_we            = 1'b0;
    if (!idx_ok) begin
      res_status = csq_pkg::ST_NO_RES;
      res_count  = '0;
    end else begin
      case (act_r)
        csq_pkg::ACT_WAIT: begin
          if (cnt_pos) begin
            if (hit_r) begin
              h_we_fin    = cmd.finish;
              h_set_valid = 1'b1;
              cnt_nxt     = cnt_cur - 1'b1;
              res_granted = 1'b1;
            end else begin
              res_status = csq_pkg::ST_HOLDER_FULL;
            end
          end else if (fill_full) begin
            res_status = csq_pkg::ST_QUEUE_FULL;
          end else begin
            w_we     = cmd.finish;
            fill_nxt = fill_cur + 1'b1;
            if (cnt_cur != csq_pkg::CNT_MIN) cnt_nxt = cnt_cur - 1'b1;
          end
        end
        csq_pkg::ACT_SIGNAL: begin
          // free the matching slot; the count goes up, saturating at CNT_MAX, even without a holder
          h_we_fin = cmd.finish && hit_r;
          if (cnt_cur != csq_pkg::CNT_MAX) cnt_nxt = cnt_cur + 1'b1;
        end
        csq_pkg::ACT_UNBLOCK: begin
          if (fill_cur != '0) begin
            res_woken_valid = 1'b1;
            res_woken_id    = w_rdata;
            fill_nxt        = fill_cur - 1'b1;
            head_nxt = (head_cur == QI_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
          end
        end
        default: ;
      endcase
      res_count = cnt_nxt;
    end
  end

  assign h_we    = cmd.clr_en || h_we_fin;
  assign h_waddr = cmd.clr_en ? clr_idx_r : base + SLOT_W'(hit_idx_r);
  assign h_wdata = cmd.clr_en ? '0 : {h_set_valid, pid_r};
  assign h_raddr = base + SLOT_W'(rd_idx_r);

  assign w_waddr = base + SLOT_W'(tail_idx);
  assign w_raddr = base + SLOT_W'(head_cur);

  csq_ram #(
    .WIDTH (ID_W + 1),
    .DEPTH (SLOTS)
  ) u_holder_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  csq_ram #(
    .WIDTH (ID_W),
    .DEPTH (SLOTS)
  ) u_waiter_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (pid_r),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        unit_count_r[r] <= csq_pkg::CNT_RESET;
        head_r[r]       <= '0;
        fill_r[r]       <= '0;
      end
      clr_idx_r   <= '0;
      rd_live_r   <= 1'b0;
      chk_live_r  <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;

      if (cmd.load) begin
        act_r  <= csq_pkg::action_t'(in_action);
        ridx_r <= in_resource_index;
        pid_r  <= in_process_id;
      end

      if (cmd.clr_en) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end

      if (cmd.scan_start) begin
        rd_idx_r   <= '0;
        rd_live_r  <= 1'b1;
        chk_live_r <= 1'b0;
        hit_r      <= 1'b0;
      end else if (cmd.scan_en) begin
        if (match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= chk_idx_r;
        end
        chk_live_r <= rd_live_r;
        chk_idx_r  <= rd_idx_r;
        if (rd_idx_r == QI_W'(QUEUE_DEPTH - 1)) begin
          rd_live_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end

      if (cmd.finish) begin
        res_status_r      <= res_status;
        res_granted_r     <= res_granted;
        res_woken_valid_r <= res_woken_valid;
        res_woken_id_r    <= res_woken_id;
        res_count_r       <= res_count;
      end

      for (int r = 0; r < NUM_RESOURCES; r++) begin
        if (cfg_wr && int'(cfg_index) == r) begin
          unit_count_r[r] <= CNT_W'(cfg_data);
        end else if (cmd.finish && idx_ok && r_sel == RES_W'(r)) begin
          unit_count_r[r] <= cnt_nxt;
          head_r[r]       <= head_nxt;
          fill_r[r]       <= fill_nxt;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_status_r;
  assign out_granted     = res_granted_r;
  assign out_woken_valid = res_woken_valid_r;
  assign out_woken_id    = res_woken_id_r;
  assign out_count_after = res_count_r;

endmodule

// ===== hw/rtl/counting_semaphore_with_wait_queue_core.sv =====
// Bank of NUM_RESOURCES counting semaphores, each with a holder set and a FIFO
// wait queue of QUEUE_DEPTH entries. A request is taken when start is high and
// busy is low; its result appears on the out_ ports for exactly one cycle with
// out_valid high and must be captured then, as there is no way to hold it off.
// Unblock, a queued wait, a wait refused for a full wait queue, an undefined
// action and any request on a bad index go from decode straight to finish.
// A wait on a positive count (granted, or refused for a full holder set) and
// a signal walk the holder set one slot per cycle through the holder RAM read
// port; a full holder set always takes the whole walk. After reset the
// holder RAM is cleared one slot per cycle with busy high; configuration
// writes are taken at any time but belong in idle periods only.
module counting_semaphore_with_wait_queue_core #(
  parameter int NUM_RESOURCES = csq_pkg::NUM_RESOURCES_DEF,
  parameter int QUEUE_DEPTH   = csq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [csq_pkg::ACT_W-1:0]         in_action,
  input  logic [csq_pkg::RIDX_W-1:0]        in_resource_index,
  input  logic [csq_pkg::ID_W-1:0]          in_process_id,
  // result channel, one-cycle strobe
  output logic                              out_valid,
  output logic [csq_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_granted,
  output logic                              out_woken_valid,
  output logic [csq_pkg::ID_W-1:0]          out_woken_id,
  output logic signed [csq_pkg::CNT_W-1:0]  out_count_after,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csq_pkg::CFG_W-1:0]         cfg_data
);

  csq_pkg::ctrl_cmd_t cmd;
  csq_pkg::dp_stat_t  stat;

  // a register write loads the unit count of its resource straight away
  assign cfg_ready = 1'b1;

  // sequencer: clear pass, decode, holder scan, finish
  csq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // counts, queue pointers, holder and waiter RAMs, result registers
  csq_dp #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_action),
    .in_resource_index (in_resource_index),
    .in_process_id     (in_process_id),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted       (out_granted),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_count_after   (out_count_after)
  );

  // each result strobe lasts a single cycle
  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a transfer always leaves the block busy for the cycle after
  a_busy_after_transfer : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after a request transfer");

  // no result strobe in the cycle right after a transfer
  a_no_result_early : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe directly after a transfer");

  // a rejected index gives a zero count and no grant or wake
  a_bad_index_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == csq_pkg::ST_NO_RES) |->
      (out_count_after == '0 && !out_granted && !out_woken_valid))
    else $error("bad index result carries data");

endmodule

// ===== tb/counting_semaphore_with_wait_queue_core_tb.sv =====
`timescale 1ns / 1ps

module counting_semaphore_with_wait_queue_core_tb;

  localparam int NRES          = csq_pkg::NUM_RESOURCES_DEF;
  localparam int QD            = csq_pkg::QUEUE_DEPTH_DEF;
  localparam int ACT_W         = csq_pkg::ACT_W;
  localparam int RIDX_W        = csq_pkg::RIDX_W;
  localparam int ID_W          = csq_pkg::ID_W;
  localparam int CNT_W         = csq_pkg::CNT_W;
  localparam int STATUS_W      = csq_pkg::STATUS_W;
  localparam int CFG_IDX_W     = csq_pkg::CFG_IDX_W;
  localparam int CFG_W         = csq_pkg::CFG_W;
  // settle margin covers a full holder walk plus the control states
  localparam int SETTLE_CYCLES = QD + 8;
  // limit sized for ~560 requests with full holder walks, plus the clearing pass
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LINES  = 40;
  // initial count registers sit at consecutive indexes, one per resource
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT_R0 = '0;

  typedef csq_pkg::action_t action_t;
  typedef csq_pkg::status_t status_t;

  typedef struct packed {
    action_t             action;
    logic [RIDX_W-1:0]   res_idx;
    logic [ID_W-1:0]     pid;
  } sem_req_t;

  typedef struct packed {
    status_t                  status;
    logic                     granted;
    logic                     woken_valid;
    logic [ID_W-1:0]          woken_id;
    logic signed [CNT_W-1:0]  count_after;
  } sem_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACT_W-1:0]         in_action = '0;
  logic [RIDX_W-1:0]        in_resource_index = '0;
  logic [ID_W-1:0]          in_process_id = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_granted;
  logic                     out_woken_valid;
  logic [ID_W-1:0]          out_woken_id;
  logic signed [CNT_W-1:0]  out_count_after;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  counting_semaphore_with_wait_queue_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_resource_index (in_resource_index),
    .in_process_id     (in_process_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted       (out_granted),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_count_after   (out_count_after),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // shadow of the semaphore bank: counts, per-resource holder multiset and
  // circular wait queue
  logic signed [CNT_W-1:0]  units        [NRES];
  logic [ID_W-1:0]          waiter_pid   [NRES][QD];
  int                       waiter_first [NRES];
  int                       waiter_count [NRES];
  logic [ID_W-1:0]          holder_pid   [NRES][QD];
  logic                     holder_used  [NRES][QD];

  sem_req_t     pending_reqs[$];   // requests not yet offered to the block
  sem_result_t  results_due[$];    // predicted results, oldest first
  int           err_count = 0;
  int           results_seen = 0;
  int           cycles = 0;
  bit           steady = 1'b0;     // set to suppress sender gaps for a stretch

  initial forever #2 clk = ~clk;

  function automatic void reset_bank();
    for (int r = 0; r < NRES; r++) begin
      units[r]        = csq_pkg::CNT_RESET;
      waiter_first[r] = 0;
      waiter_count[r] = 0;
      for (int s = 0; s < QD; s++) holder_used[r][s] = 1'b0;
    end
  endfunction

  // applies one request to the shadow bank and returns the result it gives
  function automatic sem_result_t apply_request(sem_req_t rq);
    sem_result_t res;
    int          r;
    int          slot;
    bit          freed;
    res = '0;
    r = int'(rq.res_idx);
    if (r >= NRES) begin
      res.status = csq_pkg::ST_NO_RES;
      return res;
    end
    res.status = csq_pkg::ST_OK;
    case (rq.action)
      csq_pkg::ACT_WAIT: begin
        if (units[r] > 0) begin
          // lowest free holder slot takes the id
          slot = -1;
          for (int s = QD - 1; s >= 0; s--) if (!holder_used[r][s]) slot = s;
          if (slot < 0) begin
            res.status = csq_pkg::ST_HOLDER_FULL;
          end else begin
            holder_used[r][slot] = 1'b1;
            holder_pid[r][slot]  = rq.pid;
            units[r]             = units[r] - 1;
            res.granted          = 1'b1;
          end
        end else if (waiter_count[r] >= QD) begin
          res.status = csq_pkg::ST_QUEUE_FULL;
        end else begin
          waiter_pid[r][(waiter_first[r] + waiter_count[r]) % QD] = rq.pid;
          waiter_count[r]++;
          if (units[r] != csq_pkg::CNT_MIN) units[r] = units[r] - 1;
        end
      end
      csq_pkg::ACT_SIGNAL: begin
        freed = 1'b0;
        for (int s = 0; s < QD; s++) begin
          if (!freed && holder_used[r][s] && holder_pid[r][s] == rq.pid) begin
            holder_used[r][s] = 1'b0;
            freed = 1'b1;
          end
        end
        if (units[r] != csq_pkg::CNT_MAX) units[r] = units[r] + 1;
      end
      csq_pkg::ACT_UNBLOCK: begin
        if (waiter_count[r] != 0) begin
          res.woken_valid = 1'b1;
          res.woken_id    = waiter_pid[r][waiter_first[r]];
          waiter_first[r] = (waiter_first[r] + 1) % QD;
          waiter_count[r]--;
        end
      end
      default: ;
    endcase
    res.count_after = units[r];
    return res;
  endfunction

  // mostly a handful of recurring ids so that signals find their holders
  function automatic logic [ID_W-1:0] pick_pid();
    if ($urandom_range(9) < 3) return ID_W'($urandom);
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h5a;
      3: return 8'ha5;
      4: return 8'h3c;
      5: return 8'hc3;
      6: return 8'h01;
      default: return 8'h80;
    endcase
  endfunction

  function automatic action_t pick_action();
    int d;
    d = $urandom_range(99);
    if (d < 40) return csq_pkg::ACT_WAIT;
    if (d < 70) return csq_pkg::ACT_SIGNAL;
    if (d < 95) return csq_pkg::ACT_UNBLOCK;
    return csq_pkg::ACT_NONE;
  endfunction

  function automatic void push_req(action_t a, int r, logic [ID_W-1:0] pid);
    sem_req_t rq;
    rq.action  = a;
    rq.res_idx = RIDX_W'(r);
    rq.pid     = pid;
    pending_reqs.push_back(rq);
  endfunction

  // random request on any index but the one a sequence is working on
  function automatic void push_noise(int busy_res);
    int r;
    r = $urandom_range((1 << RIDX_W) - 1);
    if (r == busy_res) r = (r + 1) % (1 << RIDX_W);
    push_req(pick_action(), r, pick_pid());
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= REPORT_LINES)
      $display("[%0t] result %0d: %s is %0h, should be %0h",
               $time, results_seen, what, got, want);
  endtask

  // one register write over the configuration channel; the shadow count is
  // reloaded at the edge the transfer happens
  task automatic write_init_count(int r, logic [CFG_W-1:0] val);
    if (!steady) repeat ($urandom_range(3)) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_INIT_COUNT_R0 + CFG_IDX_W'(r);
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    units[r]      = {{(CNT_W - CFG_W){1'b0}}, val};
    cfg_valid <= 1'b0;
  endtask

  // block quiet: nothing queued, nothing offered, nothing outstanding
  task automatic settle();
    while (pending_reqs.size() != 0 || start || results_due.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic mixed_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) r = $urandom_range((1 << RIDX_W) - 1, NRES);
      else r = $urandom_range(NRES - 1);
      push_req(pick_action(), r, pick_pid());
    end
  endtask

  // drive one count up into saturation, then pile waits onto its holder set
  task automatic climb_phase(int x);
    for (int i = 0; i < 125; i++) begin
      if ($urandom_range(9) == 0) push_noise(x);
      push_req(csq_pkg::ACT_SIGNAL, x, pick_pid());
    end
    for (int i = 0; i < QD + 4; i++) push_req(csq_pkg::ACT_WAIT, x, pick_pid());
  endtask

  // drain, fill the wait queue past full, then cycle unblock and wait pairs
  // so the count sinks to its floor and stays there
  task automatic sink_phase(int x);
    for (int i = 0; i < QD + 1; i++) push_req(csq_pkg::ACT_UNBLOCK, x, ID_W'($urandom));
    for (int i = 0; i < QD + 4; i++) push_req(csq_pkg::ACT_WAIT, x, pick_pid());
    for (int i = 0; i < 115; i++) begin
      if ($urandom_range(9) == 0) push_noise(x);
      push_req(csq_pkg::ACT_UNBLOCK, x, ID_W'($urandom));
      push_req(csq_pkg::ACT_WAIT, x, pick_pid());
    end
    for (int i = 0; i < QD + 2; i++) push_req(csq_pkg::ACT_UNBLOCK, x, ID_W'($urandom));
  endtask

  // request driver: the next request is offered only once the previous one
  // has been transferred, so the shadow bank can be advanced as it is offered
  always @(posedge clk) begin
    sem_req_t rq;
    if (rst_n && (!start || !busy)) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
        rq = pending_reqs.pop_front();
        results_due.push_back(apply_request(rq));
        start             <= 1'b1;
        in_action         <= rq.action;
        in_resource_index <= rq.res_idx;
        in_process_id     <= rq.pid;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: every strobe is taken and checked against the oldest
  // prediction
  always @(posedge clk) begin
    sem_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unrequested result, status", out_status, '0);
      end else begin
        want = results_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_granted !== want.granted)
          report_mismatch("granted", out_granted, want.granted);
        if (out_woken_valid !== want.woken_valid)
          report_mismatch("woken_valid", out_woken_valid, want.woken_valid);
        if (out_woken_id !== want.woken_id)
          report_mismatch("woken_id", out_woken_id, want.woken_id);
        if (out_count_after !== want.count_after)
          report_mismatch("count_after", out_count_after, want.count_after);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("counting_semaphore_with_wait_queue_core: mismatch");
      $finish;
    end
  end

  initial begin
    int x;
    reset_bank();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on reset counts of one: grant then queue, fifo order of
    // unblock, unblock on an empty queue, signal with and without a holder
    push_req(csq_pkg::ACT_WAIT,    0, 8'h00);
    push_req(csq_pkg::ACT_WAIT,    0, 8'hff);
    push_req(csq_pkg::ACT_WAIT,    0, 8'h5a);
    push_req(csq_pkg::ACT_UNBLOCK, 0, 8'h33);
    push_req(csq_pkg::ACT_UNBLOCK, 0, 8'h00);
    push_req(csq_pkg::ACT_UNBLOCK, 0, 8'hff);
    push_req(csq_pkg::ACT_SIGNAL,  0, 8'h00);
    push_req(csq_pkg::ACT_SIGNAL,  0, 8'h77);
    // indexes beyond the bank, for every action
    push_req(csq_pkg::ACT_WAIT,    (1 << RIDX_W) - 1, 8'hff);
    push_req(csq_pkg::ACT_SIGNAL,  NRES, 8'h12);
    push_req(csq_pkg::ACT_UNBLOCK, 5, 8'h00);
    push_req(csq_pkg::ACT_NONE,    6, 8'h55);
    // undefined action on a real resource
    push_req(csq_pkg::ACT_NONE,    1, 8'haa);
    // the same id held twice, released one at a time
    push_req(csq_pkg::ACT_WAIT,    1, 8'h42);
    push_req(csq_pkg::ACT_SIGNAL,  1, 8'h99);
    push_req(csq_pkg::ACT_WAIT,    1, 8'h42);
    push_req(csq_pkg::ACT_SIGNAL,  1, 8'h42);
    push_req(csq_pkg::ACT_SIGNAL,  1, 8'h42);
    push_req(csq_pkg::ACT_SIGNAL,  1, 8'h42);
    push_req(csq_pkg::ACT_WAIT,    3, 8'h80);
    push_req(csq_pkg::ACT_WAIT,    3, 8'h7f);
    push_req(csq_pkg::ACT_UNBLOCK, 3, 8'h01);
    settle();

    for (int r = 0; r < NRES; r++) write_init_count(r, CFG_W'($urandom));
    mixed_phase(40);
    settle();

    // one resource at the top of the register range, the rest at zero;
    // no sender gaps through this stretch
    x = $urandom_range(NRES - 1);
    steady = 1'b1;
    for (int r = 0; r < NRES; r++) write_init_count(r, (r == x) ? '1 : '0);
    climb_phase(x);
    settle();
    steady = 1'b0;

    x = $urandom_range(NRES - 1);
    for (int r = 0; r < NRES; r++) write_init_count(r, (r == x) ? '0 : '1);
    sink_phase(x);
    settle();

    for (int r = 0; r < NRES; r++) write_init_count(r, CFG_W'($urandom));
    mixed_phase(40);
    settle();

    if (err_count == 0) begin
      $display("counting_semaphore_with_wait_queue_core: match");
    end else begin
      $display("counting_semaphore_with_wait_queue_core: mismatch");
    end
    $finish;
  end

endmodule
